/* design/csr_spmv_pkg.sv */
// csr_spmv_pkg: shared types and constants for the csr sparse matrix-vector engine
// used by the controller, datapath, top level and checker; no dependencies
package csr_spmv_pkg;

    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int ROW_W     = 16;
    localparam int SUM_W     = 64;
    localparam int PROD_W    = 2 * VALUE_W;

    // widths of the stream words and the span of the index field
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = ROW_W + SUM_W;
    localparam int INDEX_SPAN = 2 ** INDEX_W;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int MAX_ROWS_DEF     = 65536;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic capture;      // latch operands of an accepted word
        logic write_vec;    // store a vector entry
        logic read_vec;     // look up the vector entry for a nonzero
        logic clear_prod;   // empty-row close adds nothing
        logic multiply;
        logic accumulate;
        logic finish;       // emit row and clear accumulator
    } csr_spmv_cmd_t;

    typedef struct packed {
        logic row_done;
        logic out_busy;
    } csr_spmv_status_t;

endpackage

/* design/csr_sparse_matrix_vector_multiply_top.sv */
// channel   dir  width                 contents
// s_axis    in   tdata 48, tuser 2     vector load, matrix nonzero or row close
// m_axis    out  tdata 80              finished row index and saturated sum
//
// a vector load or unused kind word is taken in idle; a nonzero steps through ram read,
// multiply and accumulate; a row close steps through clear product and accumulate
// a finished row sits in the output register; the block keeps accepting words
// and only holds in accumulate if a second row finishes before the first is taken
// reset clears accumulator, row counter and output valid; the vector store is
// not cleared and needs no clearing pass
//
// csr_sparse_matrix_vector_multiply_top: top level of the csr sparse matrix-vector engine
// depends on csr_spmv_pkg, csr_spmv_ctrl, csr_spmv_dp
module csr_sparse_matrix_vector_multiply_top #(
    parameter int VECTOR_DEPTH = csr_spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int MAX_ROWS     = csr_spmv_pkg::MAX_ROWS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [csr_spmv_pkg::S_DATA_W-1:0]    s_axis_tdata,  // index, value, zero pad
    input  logic [csr_spmv_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
    input  logic                                 s_axis_tlast,  // last_in_row
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [csr_spmv_pkg::M_DATA_W-1:0]    m_axis_tdata   // row_index, row_sum
);

    csr_spmv_pkg::csr_spmv_cmd_t    cmd;
    csr_spmv_pkg::csr_spmv_status_t status;
    logic [csr_spmv_pkg::ROW_W-1:0] row_index;
    logic [csr_spmv_pkg::SUM_W-1:0] row_sum;

    csr_spmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csr_spmv_dp #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .MAX_ROWS     (MAX_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_index      (s_axis_tdata[csr_spmv_pkg::INDEX_W-1:0]),
        .in_value      (s_axis_tdata[csr_spmv_pkg::INDEX_W +: csr_spmv_pkg::VALUE_W]),
        .in_last       (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_row_index (row_index),
        .out_row_sum   (row_sum)
    );

    assign m_axis_tdata = {row_sum, row_index};

endmodule

/* design/csr_spmv_ram.sv */
// csr_spmv_ram: generic single-write, single-read ram with registered read data
// no dependencies
module csr_spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/csr_spmv_ctrl.sv */
// csr_spmv_ctrl: sequencing state machine for the sparse matrix-vector engine
// depends on csr_spmv_pkg
module csr_spmv_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [csr_spmv_pkg::KIND_W-1:0]       in_kind,
    output logic                                  in_ready,
    input  csr_spmv_pkg::csr_spmv_status_t        status,
    output csr_spmv_pkg::csr_spmv_cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_kind)
                        csr_spmv_pkg::KIND_LOAD:
                        begin
                            cmd.write_vec = 1'b1;
                        end
                        csr_spmv_pkg::KIND_NONZERO:
                        begin
                            cmd.read_vec = 1'b1;
                            state_next   = ST_READ;
                        end
                        csr_spmv_pkg::KIND_CLOSE:
                        begin
                            cmd.clear_prod = 1'b1;
                            state_next     = ST_ACCUM;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.multiply = 1'b1;
                state_next   = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                // a finished row waits here until the output register frees up
                if (!(status.row_done && status.out_busy))
                begin
                    cmd.accumulate = 1'b1;
                    cmd.finish     = status.row_done;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/csr_spmv_dp.sv */
// csr_spmv_dp: vector store, multiplier, saturating accumulator, row counter, output register
// depends on csr_spmv_pkg and csr_spmv_ram
module csr_spmv_dp #(
    parameter int VECTOR_DEPTH = csr_spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int MAX_ROWS     = csr_spmv_pkg::MAX_ROWS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  csr_spmv_pkg::csr_spmv_cmd_t            cmd,
    output csr_spmv_pkg::csr_spmv_status_t         status,
    input  logic [csr_spmv_pkg::INDEX_W-1:0]       in_index,
    input  logic [csr_spmv_pkg::VALUE_W-1:0]       in_value,
    input  logic                                   in_last,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [csr_spmv_pkg::ROW_W-1:0]         out_row_index,
    output logic [csr_spmv_pkg::SUM_W-1:0]         out_row_sum
);

    localparam int STORE_SLOTS = (VECTOR_DEPTH < csr_spmv_pkg::INDEX_SPAN) ?
                                 VECTOR_DEPTH : csr_spmv_pkg::INDEX_SPAN;
    localparam int ADDR_W      = $clog2(STORE_SLOTS);

    logic                                    in_range;
    logic [csr_spmv_pkg::VALUE_W-1:0]        vec_rdata;
    logic signed [csr_spmv_pkg::VALUE_W-1:0] value_reg;
    logic                                    in_range_reg;
    logic                                    row_done_reg;
    logic signed [csr_spmv_pkg::PROD_W-1:0]  prod_reg;
    logic [csr_spmv_pkg::SUM_W-1:0]          acc_reg;
    logic [csr_spmv_pkg::SUM_W-1:0]          acc_next;
    logic [csr_spmv_pkg::SUM_W-1:0]          sum_raw;
    logic                                    ovf;
    logic [csr_spmv_pkg::ROW_W-1:0]          row_cnt_reg;
    logic [csr_spmv_pkg::ROW_W-1:0]          row_cnt_next;
    logic [csr_spmv_pkg::ROW_W:0]            row_inc;
    logic                                    out_valid_reg;
    logic [csr_spmv_pkg::ROW_W-1:0]          out_row_reg;
    logic [csr_spmv_pkg::SUM_W-1:0]          out_sum_reg;

    assign in_range = (32'(in_index) < 32'(STORE_SLOTS));

    csr_spmv_ram #(
        .WIDTH (csr_spmv_pkg::VALUE_W),
        .DEPTH (STORE_SLOTS)
    ) u_vec_ram (
        .clk     (clk),
        .wr_en   (cmd.write_vec && in_range),
        .wr_addr (in_index[ADDR_W-1:0]),
        .wr_data (in_value),
        .rd_en   (cmd.read_vec),
        .rd_addr (in_index[ADDR_W-1:0]),
        .rd_data (vec_rdata)
    );

    // saturating add: overflow only when both signs agree and the sum's differs
    always_comb
    begin
        sum_raw = acc_reg + prod_reg;
        ovf     = (acc_reg[csr_spmv_pkg::SUM_W-1] == prod_reg[csr_spmv_pkg::PROD_W-1]) &&
                  (sum_raw[csr_spmv_pkg::SUM_W-1] != acc_reg[csr_spmv_pkg::SUM_W-1]);
        if (ovf)
        begin
            acc_next = acc_reg[csr_spmv_pkg::SUM_W-1] ?
                       {1'b1, {(csr_spmv_pkg::SUM_W-1){1'b0}}} :
                       {1'b0, {(csr_spmv_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum_raw;
        end
    end

    always_comb
    begin
        row_inc = {1'b0, row_cnt_reg} + 1'b1;
        if (32'(row_inc) >= 32'(MAX_ROWS))
        begin
            row_cnt_next = '0;
        end
        else
        begin
            row_cnt_next = row_inc[csr_spmv_pkg::ROW_W-1:0];
        end
    end

    // operand and product registers carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg    <= in_value;
            in_range_reg <= in_range;
            row_done_reg <= in_last || cmd.clear_prod;
        end
        if (cmd.clear_prod)
        begin
            prod_reg <= '0;
        end
        else if (cmd.multiply)
        begin
            if (in_range_reg)
            begin
                prod_reg <= value_reg * $signed(vec_rdata);
            end
            else
            begin
                prod_reg <= '0;
            end
        end
        if (cmd.finish)
        begin
            out_row_reg <= row_cnt_reg;
            out_sum_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                acc_reg     <= '0;
                row_cnt_reg <= row_cnt_next;
            end
            else if (cmd.accumulate)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.row_done = row_done_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign out_row_index = out_row_reg;
    assign out_row_sum   = out_sum_reg;

endmodule

/* design/csr_spmv_checker.sv */
// csr_spmv_checker: port-level assertions for the csr sparse matrix-vector engine
// depends on csr_spmv_pkg; bound to csr_sparse_matrix_vector_multiply_top
module csr_spmv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [csr_spmv_pkg::KIND_W-1:0]   s_axis_tuser,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [csr_spmv_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a vector load never produces a row
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == csr_spmv_pkg::KIND_LOAD && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("vector load produced a result");

    // a nonzero that does not end its row yields nothing over its whole run
    a_mid_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == csr_spmv_pkg::KIND_NONZERO && !s_axis_tlast && !m_axis_tvalid
        |=> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("non-final nonzero produced a result");

    // nonzeros and row closes keep the input busy for the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_axis_tuser == csr_spmv_pkg::KIND_NONZERO ||
                  s_axis_tuser == csr_spmv_pkg::KIND_CLOSE) |=> !s_axis_tready)
        else $error("input accepted while a word was in flight");

endmodule

bind csr_sparse_matrix_vector_multiply_top csr_spmv_checker u_csr_spmv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
